FILE: src/ssd_pkg.sv
// Shared types and constants for the segment-to-segment distance block.
// Used by every module of the block; depends on nothing else.
package ssd_pkg;

  localparam int CoordW     = 16;               // Q8.8 input coordinate
  localparam int NumCoords  = 8;
  localparam int InTdataW   = CoordW * NumCoords;
  localparam int VecW       = CoordW + 1;       // Q9.8 difference vector
  localparam int DotW       = 2 * VecW + 1;     // dot products, 16 fraction bits
  localparam int WideW      = 2 * DotW;         // determinant and numerators
  localparam int FracW      = 16;               // Q0.16 parameter
  localparam int ParW       = FracW + 1;        // parameter 0 .. 65536
  localparam int DiffW      = VecW + FracW + 3; // difference vector, 24 fraction bits
  localparam int MagW       = DiffW - 1;
  localparam int SqW        = 2 * MagW + 1;     // squared length, 48 fraction bits
  localparam int SqDrop     = 32;
  localparam int RadW       = SqW - SqDrop;     // radicand of the square root
  localparam int RootW      = (RadW + 1) / 2;
  localparam int OutW       = 17;               // Q9.8 distance
  localparam int OutTdataW  = ((OutW + 7) / 8) * 8;
  localparam logic [OutW-1:0] OutMax = '1;
  localparam int QueueDepthDef = 4;

  typedef struct packed {
    logic signed [VecW-1:0] ux;
    logic signed [VecW-1:0] uy;
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [VecW-1:0] wx;
    logic signed [VecW-1:0] wy;
  } vec_t;

  // One classified query as it travels from the front end to the back end.
  typedef struct packed {
    logic signed [WideW-1:0] s_num;
    logic signed [WideW-1:0] s_den;
    logic signed [WideW-1:0] t_num;
    logic signed [WideW-1:0] t_den;
    vec_t                    vec;
  } item_t;

endpackage

FILE: src/ssd_front.sv
// Front end: difference vectors, dot products, determinant and the clamping
// of both closest-point parameters. Depends on ssd_pkg.
module ssd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ssd_pkg::InTdataW-1:0] in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ssd_pkg::item_t           out_item_o
);
  import ssd_pkg::*;

  localparam int NStg = 6;

  logic [NStg-1:0] vld_q;
  logic            en;

  vec_t s1_vec_q, s2_vec_q, s3_vec_q, s4_vec_q, s5_vec_q;
  logic signed [DotW-1:0] s2_a_q, s2_b_q, s2_c_q, s2_d_q, s2_e_q;
  logic signed [DotW-1:0] s3_a_q, s3_b_q, s3_c_q, s3_d_q, s3_e_q;
  logic signed [DotW-1:0] s4_a_q, s4_b_q, s4_c_q, s4_d_q, s4_e_q;
  logic signed [DotW-1:0] s5_a_q, s5_b_q, s5_d_q;
  logic signed [WideW-1:0] s3_ac_q, s3_bb_q, s3_be_q, s3_cd_q, s3_ae_q, s3_bd_q;
  logic signed [WideW-1:0] s4_det_q, s4_sn_q, s4_tn_q;
  logic signed [WideW-1:0] s5_sn_q, s5_sd_q, s5_tn_q, s5_td_q;
  logic signed [WideW-1:0] s5_sn_d, s5_sd_d, s5_tn_d, s5_td_d;
  logic signed [WideW-1:0] s6_sn_d, s6_sd_d, s6_tn_d;
  logic signed [DotW-1:0]  alt;
  logic                    t_clamped;
  logic signed [CoordW-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
  item_t out_item_q;

  assign en          = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg-1];
  assign out_item_o  = out_item_q;

  assign p0x = $signed(in_data_i[0*CoordW +: CoordW]);
  assign p0y = $signed(in_data_i[1*CoordW +: CoordW]);
  assign p1x = $signed(in_data_i[2*CoordW +: CoordW]);
  assign p1y = $signed(in_data_i[3*CoordW +: CoordW]);
  assign q0x = $signed(in_data_i[4*CoordW +: CoordW]);
  assign q0y = $signed(in_data_i[5*CoordW +: CoordW]);
  assign q1x = $signed(in_data_i[6*CoordW +: CoordW]);
  assign q1y = $signed(in_data_i[7*CoordW +: CoordW]);

  // Parameter clamping for s; a non-positive determinant means parallel lines.
  always_comb begin
    s5_sn_d = s4_sn_q;
    s5_sd_d = s4_det_q;
    s5_tn_d = s4_tn_q;
    s5_td_d = s4_det_q;
    if (s4_det_q <= 0) begin
      s5_sn_d = '0;
      s5_sd_d = WideW'(1);
      s5_tn_d = WideW'(s4_e_q);
      s5_td_d = WideW'(s4_c_q);
    end else if (s4_sn_q < 0) begin
      s5_sn_d = '0;
      s5_tn_d = WideW'(s4_e_q);
      s5_td_d = WideW'(s4_c_q);
    end else if (s4_sn_q > s4_det_q) begin
      s5_sn_d = s4_det_q;
      s5_tn_d = WideW'(s4_e_q) + WideW'(s4_b_q);
      s5_td_d = WideW'(s4_c_q);
    end
  end

  // Clamp t, then solve s again against the clamped end of the second segment.
  always_comb begin
    s6_tn_d   = s5_tn_q;
    s6_sn_d   = s5_sn_q;
    s6_sd_d   = s5_sd_q;
    alt       = '0;
    t_clamped = 1'b0;
    if (s5_tn_q < 0) begin
      s6_tn_d   = '0;
      alt       = -s5_d_q;
      t_clamped = 1'b1;
    end else if (s5_tn_q > s5_td_q) begin
      s6_tn_d   = s5_td_q;
      alt       = s5_b_q - s5_d_q;
      t_clamped = 1'b1;
    end
    if (t_clamped) begin
      if (alt < 0) begin
        s6_sn_d = '0;
      end else if (alt > s5_a_q) begin
        s6_sn_d = s5_sd_q;
      end else begin
        s6_sn_d = WideW'(alt);
        s6_sd_d = WideW'(s5_a_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_vec_q.ux <= VecW'(p0x) - VecW'(p1x);
      s1_vec_q.uy <= VecW'(p0y) - VecW'(p1y);
      s1_vec_q.vx <= VecW'(q0x) - VecW'(q1x);
      s1_vec_q.vy <= VecW'(q0y) - VecW'(q1y);
      s1_vec_q.wx <= VecW'(p1x) - VecW'(q1x);
      s1_vec_q.wy <= VecW'(p1y) - VecW'(q1y);

      s2_vec_q <= s1_vec_q;
      s2_a_q <= DotW'(s1_vec_q.ux) * DotW'(s1_vec_q.ux)
              + DotW'(s1_vec_q.uy) * DotW'(s1_vec_q.uy);
      s2_b_q <= DotW'(s1_vec_q.ux) * DotW'(s1_vec_q.vx)
              + DotW'(s1_vec_q.uy) * DotW'(s1_vec_q.vy);
      s2_c_q <= DotW'(s1_vec_q.vx) * DotW'(s1_vec_q.vx)
              + DotW'(s1_vec_q.vy) * DotW'(s1_vec_q.vy);
      s2_d_q <= DotW'(s1_vec_q.ux) * DotW'(s1_vec_q.wx)
              + DotW'(s1_vec_q.uy) * DotW'(s1_vec_q.wy);
      s2_e_q <= DotW'(s1_vec_q.vx) * DotW'(s1_vec_q.wx)
              + DotW'(s1_vec_q.vy) * DotW'(s1_vec_q.wy);

      s3_vec_q <= s2_vec_q;
      s3_a_q <= s2_a_q;
      s3_b_q <= s2_b_q;
      s3_c_q <= s2_c_q;
      s3_d_q <= s2_d_q;
      s3_e_q <= s2_e_q;
      s3_ac_q <= WideW'(s2_a_q) * WideW'(s2_c_q);
      s3_bb_q <= WideW'(s2_b_q) * WideW'(s2_b_q);
      s3_be_q <= WideW'(s2_b_q) * WideW'(s2_e_q);
      s3_cd_q <= WideW'(s2_c_q) * WideW'(s2_d_q);
      s3_ae_q <= WideW'(s2_a_q) * WideW'(s2_e_q);
      s3_bd_q <= WideW'(s2_b_q) * WideW'(s2_d_q);

      s4_vec_q <= s3_vec_q;
      s4_a_q <= s3_a_q;
      s4_b_q <= s3_b_q;
      s4_c_q <= s3_c_q;
      s4_d_q <= s3_d_q;
      s4_e_q <= s3_e_q;
      s4_det_q <= s3_ac_q - s3_bb_q;
      s4_sn_q  <= s3_be_q - s3_cd_q;
      s4_tn_q  <= s3_ae_q - s3_bd_q;

      s5_vec_q <= s4_vec_q;
      s5_a_q <= s4_a_q;
      s5_b_q <= s4_b_q;
      s5_d_q <= s4_d_q;
      s5_sn_q <= s5_sn_d;
      s5_sd_q <= s5_sd_d;
      s5_tn_q <= s5_tn_d;
      s5_td_q <= s5_td_d;

      out_item_q.vec   <= s5_vec_q;
      out_item_q.s_num <= s6_sn_d;
      out_item_q.s_den <= s6_sd_d;
      out_item_q.t_num <= s6_tn_d;
      out_item_q.t_den <= s5_td_q;
    end
  end

endmodule

FILE: src/ssd_queue.sv
// Short queue of classified queries between the front and back ends.
// Depends on ssd_pkg for the item type.
module ssd_queue #(
  parameter int Depth = ssd_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ssd_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ssd_pkg::item_t pop_item_o
);
  import ssd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop, full;

  assign full         = (count_q == CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop          = pop_valid_o && pop_ready_i;
  // A slot freed by a pop in the same cycle may be refilled at once.
  assign push_ready_o = !full || pop_ready_i;
  assign push         = push_valid_i && push_ready_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/ssd_div.sv
// Pipelined restoring divider giving floor(65536 * n / d) clamped to 0 .. 65536,
// one quotient bit per stage. Depends on ssd_pkg.
module ssd_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ssd_pkg::WideW-1:0] num_i,
  input  logic signed [ssd_pkg::WideW-1:0] den_i,
  output logic [ssd_pkg::ParW-1:0]      quot_o
);
  import ssd_pkg::*;

  localparam int RemW = WideW + 1;

  logic [RemW-1:0]  rem_q  [FracW+1];
  logic [RemW-1:0]  den_q  [FracW+1];
  logic [FracW-1:0] q_q    [FracW+1];
  logic             zero_q [FracW+1];
  logic             one_q  [FracW+1];
  logic [RemW-1:0]  rem_d  [FracW];
  logic [FracW-1:0] q_d    [FracW];
  logic [RemW-1:0]  shifted [FracW];

  always_comb begin
    for (int k = 0; k < FracW; k++) begin
      shifted[k] = rem_q[k] << 1;
      if (shifted[k] >= den_q[k]) begin
        rem_d[k] = shifted[k] - den_q[k];
        q_d[k]   = {q_q[k][FracW-2:0], 1'b1};
      end else begin
        rem_d[k] = shifted[k];
        q_d[k]   = {q_q[k][FracW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RemW'(num_i);
      den_q[0]  <= RemW'(den_i);
      q_q[0]    <= '0;
      zero_q[0] <= (num_i <= 0) || (den_i <= 0);
      one_q[0]  <= (num_i >= den_i);
      for (int k = 0; k < FracW; k++) begin
        rem_q[k+1]  <= rem_d[k];
        den_q[k+1]  <= den_q[k];
        q_q[k+1]    <= q_d[k];
        zero_q[k+1] <= zero_q[k];
        one_q[k+1]  <= one_q[k];
      end
    end
  end

  always_comb begin
    if (zero_q[FracW]) begin
      quot_o = '0;
    end else if (one_q[FracW]) begin
      quot_o = ParW'(1) << FracW;
    end else begin
      quot_o = {1'b0, q_q[FracW]};
    end
  end

endmodule

FILE: src/ssd_back.sv
// Back end: both parameter divisions, the difference vector, its squared length
// and a pipelined square root. Depends on ssd_pkg and ssd_div.
module ssd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ssd_pkg::item_t            in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssd_pkg::OutW-1:0]  out_dist_o
);
  import ssd_pkg::*;

  localparam int DivLat = FracW + 1;
  localparam int IdxM1  = DivLat;
  localparam int IdxM2  = DivLat + 1;
  localparam int IdxM3  = DivLat + 2;
  localparam int IdxRad = DivLat + 3;
  localparam int NStg   = IdxRad + RootW + 2;
  localparam int ResW   = RadW + 1;

  logic [NStg-1:0] vld_q;
  logic            en;
  logic [ParW-1:0] sc, tc;
  vec_t            vec_q [DivLat];

  logic signed [DiffW-1:0] usx_q, usy_q, vtx_q, vty_q;
  logic signed [VecW-1:0]  m1_wx_q, m1_wy_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic [MagW-1:0]         mag_x, mag_y;
  logic [2*MagW-1:0]       sqx_q, sqy_q;
  logic [SqW-1:0]          sq_sum;
  logic [ResW-1:0]         x_q [RootW+1];
  logic [ResW-1:0]         r_q [RootW+1];
  logic [ResW-1:0]         x_d [RootW];
  logic [ResW-1:0]         r_d [RootW];
  logic [ResW-1:0]         trial [RootW];
  logic [OutW-1:0]         dist_q;

  assign en          = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg-1];
  assign out_dist_o  = dist_q;

  ssd_div u_div_s (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (in_item_i.s_num),
    .den_i  (in_item_i.s_den),
    .quot_o (sc)
  );

  ssd_div u_div_t (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (in_item_i.t_num),
    .den_i  (in_item_i.t_den),
    .quot_o (tc)
  );

  assign mag_x  = MagW'(dx_q < 0 ? -dx_q : dx_q);
  assign mag_y  = MagW'(dy_q < 0 ? -dy_q : dy_q);
  assign sq_sum = SqW'(sqx_q) + SqW'(sqy_q);

  // Bit-by-bit square root, one result bit per stage.
  always_comb begin
    for (int k = 0; k < RootW; k++) begin
      trial[k] = r_q[k] + (ResW'(1) << (2 * (RootW - 1 - k)));
      if (x_q[k] >= trial[k]) begin
        x_d[k] = x_q[k] - trial[k];
        r_d[k] = (r_q[k] >> 1) + (ResW'(1) << (2 * (RootW - 1 - k)));
      end else begin
        x_d[k] = x_q[k];
        r_d[k] = r_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q[0] <= in_item_i.vec;
      for (int k = 1; k < DivLat; k++) begin
        vec_q[k] <= vec_q[k-1];
      end
      usx_q   <= DiffW'(vec_q[DivLat-1].ux) * DiffW'($signed({1'b0, sc}));
      usy_q   <= DiffW'(vec_q[DivLat-1].uy) * DiffW'($signed({1'b0, sc}));
      vtx_q   <= DiffW'(vec_q[DivLat-1].vx) * DiffW'($signed({1'b0, tc}));
      vty_q   <= DiffW'(vec_q[DivLat-1].vy) * DiffW'($signed({1'b0, tc}));
      m1_wx_q <= vec_q[DivLat-1].wx;
      m1_wy_q <= vec_q[DivLat-1].wy;
      dx_q    <= (DiffW'(m1_wx_q) <<< FracW) + usx_q - vtx_q;
      dy_q    <= (DiffW'(m1_wy_q) <<< FracW) + usy_q - vty_q;
      sqx_q   <= mag_x * mag_x;
      sqy_q   <= mag_y * mag_y;
      x_q[0]  <= ResW'(sq_sum[SqW-1:SqDrop]);
      r_q[0]  <= '0;
      for (int k = 0; k < RootW; k++) begin
        x_q[k+1] <= x_d[k];
        r_q[k+1] <= r_d[k];
      end
      dist_q <= (r_q[RootW] > ResW'(OutMax)) ? OutMax : r_q[RootW][OutW-1:0];
    end
  end

endmodule

FILE: src/segment_segment_distance_2d.sv
// Top level of the segment-to-segment distance block.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.
//
// Each input word on the s_axis channel carries two segments P = (p0, p1) and
// Q = (q0, q1) as eight signed Q8.8 coordinates. The block returns one word on
// the m_axis channel per input word: the shortest distance between the two
// segments as unsigned Q9.8, with the square root truncated toward zero.
// Words come out in the order they went in; the block keeps no state between
// queries.
//
// Throughput is one word per clock cycle while m_axis_tready is high. From
// acceptance, a word passes through 6 front-end stages (vectors, dot products,
// wide products, determinant, two clamping steps), the queue register, the
// two parallel 16-bit dividers, the registers for the difference vector and
// its square, the square-root stages and the output register. The dividers
// and the square root each resolve one result bit per stage.
//
// Reset clears all valid flags and the queue; no output word is presented
// until new input arrives. When the receiver holds m_axis_tready low, the back
// end freezes, the queue fills, and only then does s_axis_tready fall.
module segment_segment_distance_2d #(
  parameter int QueueDepth = ssd_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0 up: seg1_end0_x, seg1_end0_y, seg1_end1_x, seg1_end1_y,
  // seg2_end0_x, seg2_end0_y, seg2_end1_x, seg2_end1_y (16 bits each).
  input  logic [ssd_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0 up: min_distance (17 bits), then zero padding.
  output logic [ssd_pkg::OutTdataW-1:0]  m_axis_tdata
);
  import ssd_pkg::*;

  // Front end to queue.
  logic  fq_valid, fq_ready;
  item_t fq_item;
  // Queue to back end.
  logic  qb_valid, qb_ready;
  item_t qb_item;
  logic [OutW-1:0] dist_word;

  ssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fq_valid),
    .out_ready_i (fq_ready),
    .out_item_o  (fq_item)
  );

  // The queue lets the front end keep accepting while the back end is stalled.
  ssd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_item_i   (qb_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dist_o  (dist_word)
  );

  assign m_axis_tdata = OutTdataW'(dist_word);

endmodule

FILE: src/ssd_checker.sv
// Port-level checks for the segment-to-segment distance block, bound to the
// top level. Depends on ssd_pkg.
module ssd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ssd_pkg::OutTdataW-1:0] m_axis_tdata
);
  import ssd_pkg::*;

  // A stalled result word stays presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // With nothing waiting at the output the pipeline drains, so input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is idle");

  // Padding above the distance field is always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> OutW) == '0)
    else $error("nonzero padding in output word");

endmodule

bind segment_segment_distance_2d ssd_checker u_ssd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
